FILE: rtl/assert_macros.svh
// assertion macros shared by the bar width code reader rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bwcr_pkg.sv
// shared types and constants of the bar width code reader
// no dependencies; imported by every module of the block
package bwcr_pkg;

    // default sizes
    localparam int CODE_BITS_DEF   = 14;
    localparam int CAL_BARS_DEF    = 6;
    localparam int TICK_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    // configuration registers
    localparam int CFG_W = 14;
    localparam logic [CFG_W-1:0] FIRST_CODE_RST  = 14'd13003;
    localparam logic [CFG_W-1:0] SECOND_CODE_RST = 14'd9529;
    localparam logic REG_FIRST_CODE  = 1'b0;
    localparam logic REG_SECOND_CODE = 1'b1;

    // request operations
    localparam logic OP_EDGE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_BIT        = 2'd0;
    localparam logic [1:0] KIND_ACCEPT     = 2'd1;
    localparam logic [1:0] KIND_REJECT     = 2'd2;
    localparam logic [1:0] KIND_INCOMPLETE = 2'd3;

    typedef struct packed {
        logic full;
        logic empty;
    } bwcr_qstat_t;

endpackage

FILE: rtl/bwcr_div.sv
// restoring divider, one quotient bit per cycle
// depends on bwcr_pkg; used by bwcr_back for the run length
module bwcr_div
    import bwcr_pkg::*;
#(
    parameter int W = 19
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W:0]       rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W:0]       trial;
    logic             fits;

    assign trial = {rem_reg[W-1:0], quo_reg[W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            cnt_next  = CNT_W'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (trial - {1'b0, div_reg}) : trial;
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/bwcr_queue.sv
// small register fifo between the front and back of the reader
// depends on bwcr_pkg and assert_macros.svh
`include "assert_macros.svh"
module bwcr_queue
    import bwcr_pkg::*;
#(
    parameter int WIDTH = 17,
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output bwcr_qstat_t      stat
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    assign stat.full  = count_reg == CNT_W'(DEPTH);
    assign stat.empty = count_reg == '0;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    `ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !(push && stat.full), "queue push while full")
    `ASSERT_ALWAYS(a_no_underflow, clk, rst_n, !(pop && stat.empty), "queue pop while empty")

endmodule

FILE: rtl/bwcr_front.sv
// input side: takes requests and classifies them into queue entries
// depends on bwcr_pkg; feeds bwcr_queue
module bwcr_front
    import bwcr_pkg::*;
#(
    parameter int TICK_BITS = TICK_BITS_DEF
)
(
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [TICK_BITS-1:0] interval,
    input  bwcr_qstat_t          q_stat,
    output logic                 q_push,
    output logic [TICK_BITS:0]   q_data
);

    logic op;

    assign in_stall = q_stat.full;
    assign q_push   = in_valid && !q_stat.full;
    assign op       = action ? OP_TIMEOUT : OP_EDGE;

    // a timeout carries no interval
    assign q_data = {op, (op == OP_TIMEOUT) ? {TICK_BITS{1'b0}} : interval};

endmodule

FILE: rtl/bwcr_back.sv
// execution side: calibration, run length decode, bit emission, verdict
// depends on bwcr_pkg, bwcr_div and assert_macros.svh
`include "assert_macros.svh"
module bwcr_back
    import bwcr_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF,
    parameter int CAL_BARS  = CAL_BARS_DEF,
    parameter int TICK_BITS = TICK_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bwcr_qstat_t          q_stat,
    input  logic [TICK_BITS:0]   q_data,
    output logic                 q_pop,
    input  logic [CFG_W-1:0]     first_code,
    input  logic [CFG_W-1:0]     second_code,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           kind,
    output logic                 bit_value,
    output logic                 user_index,
    output logic                 last
);

    localparam int PH_W  = $clog2(CAL_BARS + 2);
    localparam int SUM_W = TICK_BITS + $clog2(CAL_BARS);
    localparam int BC_W  = $clog2(CODE_BITS + 1);
    localparam int DIV_W = TICK_BITS + 2;
    localparam int CMP_W = (CODE_BITS > CFG_W) ? CODE_BITS : CFG_W;
    localparam logic [CMP_W-1:0] CODE_MASK = CMP_W'((65'(1) << CODE_BITS) - 65'(1));

    // sum / CAL_BARS as a reciprocal multiply, exact over the whole sum range
    localparam int CAL_SH = SUM_W + $clog2(CAL_BARS);
    localparam int MUL_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + MUL_W;
    localparam logic [MUL_W-1:0] CAL_MUL =
        MUL_W'(((64'd1 << CAL_SH) + 64'(CAL_BARS - 1)) / 64'(CAL_BARS));

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DIV_CAL = 3'd1;
    localparam logic [2:0] S_DIV_RUN = 3'd2;
    localparam logic [2:0] S_EMIT    = 3'd3;
    localparam logic [2:0] S_VERDICT = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [PH_W-1:0]      phase_reg, phase_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [TICK_BITS-1:0] bar_reg, bar_next;
    logic                 pol_reg, pol_next;
    logic [CODE_BITS-1:0] code_reg, code_next;
    logic [BC_W-1:0]      count_reg, count_next;
    logic [BC_W-1:0]      run_reg, run_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           kind_reg, kind_next;
    logic                 bit_reg, bit_next;
    logic                 user_reg, user_next;
    logic                 last_reg, last_next;

    logic                 q_op;
    logic [TICK_BITS-1:0] q_iv;
    logic [SUM_W-1:0]     sum_add;
    logic                 out_free;
    logic                 clear;
    logic                 emit;
    logic [1:0]           e_kind;
    logic                 e_bit;
    logic                 e_user;
    logic                 e_last;
    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [DIV_W-1:0]     div_divisor;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quo;
    logic [PROD_W-1:0]    cal_prod;
    logic [TICK_BITS-1:0] cal_bar;
    logic [BC_W-1:0]      room;
    logic [CMP_W-1:0]     code_ext;
    logic [CMP_W-1:0]     first_ext;
    logic [CMP_W-1:0]     second_ext;
    logic                 verdict_out;

    assign q_op        = q_data[TICK_BITS];
    assign q_iv        = q_data[TICK_BITS-1:0];
    assign sum_add     = sum_reg + SUM_W'(q_iv);
    assign out_free    = !out_valid_reg || !out_stall;
    assign cal_prod    = PROD_W'(sum_reg) * PROD_W'(CAL_MUL);
    assign cal_bar     = cal_prod[CAL_SH +: TICK_BITS];
    assign room        = BC_W'(CODE_BITS) - count_reg;
    assign code_ext    = CMP_W'(code_reg);
    assign first_ext   = CMP_W'(first_code) & CODE_MASK;
    assign second_ext  = CMP_W'(second_code) & CODE_MASK;
    assign verdict_out = out_valid_reg && kind_reg != KIND_BIT;

    bwcr_div #(
        .W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        sum_next     = sum_reg;
        bar_next     = bar_reg;
        pol_next     = pol_reg;
        code_next    = code_reg;
        count_next   = count_reg;
        run_next     = run_reg;
        q_pop        = 1'b0;
        clear        = 1'b0;
        emit         = 1'b0;
        e_kind       = KIND_BIT;
        e_bit        = 1'b0;
        e_user       = 1'b0;
        e_last       = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty && out_free)
                begin
                    q_pop = 1'b1;
                    if (q_op == OP_TIMEOUT)
                    begin
                        if (count_reg != '0 && count_reg < BC_W'(CODE_BITS))
                        begin
                            emit   = 1'b1;
                            e_kind = KIND_INCOMPLETE;
                            e_last = 1'b1;
                        end
                        clear = 1'b1;
                    end
                    else if (phase_reg == '0)
                    begin
                        // first edge only starts timing
                        phase_next = PH_W'(1);
                        sum_next   = '0;
                    end
                    else if (phase_reg <= PH_W'(CAL_BARS))
                    begin
                        sum_next   = sum_add;
                        phase_next = phase_reg + PH_W'(1);
                        if (phase_reg == PH_W'(CAL_BARS))
                            state_next = S_DIV_CAL;
                    end
                    else
                    begin
                        // round half up: (2*interval + bar) / (2*bar)
                        div_start    = 1'b1;
                        div_dividend = DIV_W'({q_iv, 1'b0}) + DIV_W'(bar_reg);
                        div_divisor  = DIV_W'({bar_reg, 1'b0});
                        state_next   = S_DIV_RUN;
                    end
                end
            end
            S_DIV_CAL:
            begin
                bar_next   = (cal_bar == '0) ? TICK_BITS'(1) : cal_bar;
                state_next = S_IDLE;
            end
            S_DIV_RUN:
            begin
                if (div_done)
                begin
                    if (div_quo == '0)
                        run_next = BC_W'(1);
                    else if (div_quo > DIV_W'(room))
                        run_next = room;
                    else
                        run_next = div_quo[BC_W-1:0];
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_BIT;
                    e_bit      = pol_reg;
                    code_next  = {code_reg[CODE_BITS-2:0], pol_reg};
                    count_next = count_reg + BC_W'(1);
                    run_next   = run_reg - BC_W'(1);
                    if (run_reg == BC_W'(1))
                    begin
                        pol_next = !pol_reg;
                        if (count_reg + BC_W'(1) == BC_W'(CODE_BITS))
                            state_next = S_VERDICT;
                        else
                        begin
                            e_last     = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else if (count_reg + BC_W'(1) == BC_W'(CODE_BITS))
                        state_next = S_VERDICT;
                end
            end
            S_VERDICT:
            begin
                if (out_free)
                begin
                    emit   = 1'b1;
                    e_last = 1'b1;
                    if (code_ext == first_ext)
                        e_kind = KIND_ACCEPT;
                    else if (code_ext == second_ext)
                    begin
                        e_kind = KIND_ACCEPT;
                        e_user = 1'b1;
                    end
                    else
                        e_kind = KIND_REJECT;
                    clear      = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (clear)
        begin
            phase_next = '0;
            sum_next   = '0;
            bar_next   = '0;
            pol_next   = 1'b1;
            code_next  = '0;
            count_next = '0;
            run_next   = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        bit_next       = bit_reg;
        user_next      = user_reg;
        last_next      = last_reg;
        if (out_free)
        begin
            out_valid_next = emit;
            kind_next      = e_kind;
            bit_next       = e_bit;
            user_next      = e_user;
            last_next      = e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            sum_reg       <= '0;
            bar_reg       <= '0;
            pol_reg       <= 1'b1;
            code_reg      <= '0;
            count_reg     <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            bar_reg       <= bar_next;
            pol_reg       <= pol_next;
            code_reg      <= code_next;
            count_reg     <= count_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        bit_reg  <= bit_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign bit_value  = bit_reg;
    assign user_index = user_reg;
    assign last       = last_reg;

    `ASSERT_ALWAYS(a_count_max, clk, rst_n, count_reg <= BC_W'(CODE_BITS), "bit count overrun")
    `ASSERT_IMPLY(a_emit_run, clk, rst_n, state_reg == S_EMIT, run_reg != '0, "empty run in emit")
    `ASSERT_IMPLY(a_verdict_last, clk, rst_n, verdict_out, last_reg, "verdict not last")
    `ASSERT_IMPLY(a_div_owner, clk, rst_n, div_done, state_reg == S_DIV_RUN, "stray divide")

endmodule

FILE: rtl/bar_width_code_reader_unit.sv
// bar width code reader: decodes a card of bars from edge intervals
// input channel: in_valid/in_stall with action (0 edge, 1 timeout) and interval
// in ticks since the previous edge; a request is taken when valid is high and
// stall is low. output channel: out_valid/out_stall with kind, bit_value,
// user_index and last; last marks the final result of one request.
// the first edge starts timing, the next six set the bar time, and each later
// edge yields a run of alternating bits until fourteen are held, followed by
// an accepted or rejected verdict against the two user code registers.
// a timeout clears everything and reports incomplete if a partial code is held.
// a request is written into the queue and leaves it once the back end is idle
// and the output is free; timeouts and calibration edges are carried out as
// they leave the queue, and the last calibration edge then sets the bar time.
// a decode edge starts the divider (one quotient bit per cycle), then the bits of
// its run follow one per cycle while the output is not stalled, and the verdict
// comes after the fourteenth bit; requests are carried out one at a time.
// a two-entry queue parts intake from execution; an output stall holds the
// result register and the back end waits on it while the queue still fills.
// reset clears all decode state; user codes return to their reset values.
// depends on bwcr_pkg, bwcr_front, bwcr_queue, bwcr_back
module bar_width_code_reader_unit
    import bwcr_pkg::*;
#(
    parameter int CODE_BITS   = CODE_BITS_DEF,
    parameter int CAL_BARS    = CAL_BARS_DEF,
    parameter int TICK_BITS   = TICK_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [TICK_BITS-1:0] interval,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           kind,
    output logic                 bit_value,
    output logic                 user_index,
    output logic                 last
);

    logic [CFG_W-1:0]   first_code_reg, first_code_next;
    logic [CFG_W-1:0]   second_code_reg, second_code_next;
    bwcr_qstat_t        q_stat;
    logic               q_push;
    logic               q_pop;
    logic [TICK_BITS:0] q_wdata;
    logic [TICK_BITS:0] q_rdata;

    always_comb
    begin
        first_code_next  = first_code_reg;
        second_code_next = second_code_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FIRST_CODE:  first_code_next  = cfg_data;
                REG_SECOND_CODE: second_code_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_code_reg  <= FIRST_CODE_RST;
            second_code_reg <= SECOND_CODE_RST;
        end
        else
        begin
            first_code_reg  <= first_code_next;
            second_code_reg <= second_code_next;
        end
    end

    bwcr_front #(
        .TICK_BITS (TICK_BITS)
    ) u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .interval (interval),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    bwcr_queue #(
        .WIDTH (TICK_BITS + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .stat      (q_stat)
    );

    bwcr_back #(
        .CODE_BITS (CODE_BITS),
        .CAL_BARS  (CAL_BARS),
        .TICK_BITS (TICK_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .first_code  (first_code_reg),
        .second_code (second_code_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .bit_value   (bit_value),
        .user_index  (user_index),
        .last        (last)
    );

endmodule

FILE: bench/bar_width_code_reader_checker.sv
// result checker for the bar width code reader: predicts decoded bits and
// verdicts from accepted requests and compares every result in order
// depends on bwcr_pkg
module bar_width_code_reader_checker
    import bwcr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic                     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic                     action,
    input  logic [TICK_BITS_DEF-1:0] interval,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [1:0]               kind,
    input  logic                     bit_value,
    input  logic                     user_index,
    input  logic                     last,
    output int                       failures,
    output int                       outstanding
);

    typedef struct packed {
        logic [1:0] kind;
        logic       bit_value;
        logic       user_index;
        logic       last;
    } reader_result_t;

    logic [CFG_W-1:0]         user_code [2];
    logic [2:0]               cal_phase;
    logic [18:0]              cal_sum;
    logic [TICK_BITS_DEF-1:0] bar_time;
    logic                     polarity;
    logic [CODE_BITS_DEF-1:0] code_reg;
    logic [3:0]               held_bits;
    reader_result_t           expected_results [$];
    int                       mismatches;

    task automatic clear_card();
        cal_phase = '0;
        cal_sum   = '0;
        bar_time  = '0;
        polarity  = 1'b1;
        code_reg  = '0;
        held_bits = '0;
    endtask

    task automatic decode_request(input logic op, input logic [TICK_BITS_DEF-1:0] ticks);
        reader_result_t fresh [$];
        reader_result_t tail;
        int bar;
        int run;
        int room;
        if (op == OP_TIMEOUT)
        begin
            // partial code only; an empty or full register reports nothing
            if (held_bits > 0 && held_bits < CODE_BITS_DEF)
                fresh.push_back('{KIND_INCOMPLETE, 1'b0, 1'b0, 1'b0});
            clear_card();
        end
        else if (cal_phase == 0)
        begin
            cal_phase = 3'd1;
            cal_sum   = '0;
        end
        else if (cal_phase <= CAL_BARS_DEF)
        begin
            cal_sum = cal_sum + ticks;
            if (cal_phase == CAL_BARS_DEF)
            begin
                bar_time = TICK_BITS_DEF'(cal_sum / CAL_BARS_DEF);
                if (bar_time == 0)
                    bar_time = 1;
            end
            cal_phase = cal_phase + 3'd1;
        end
        else
        begin
            bar = (bar_time == 0) ? 1 : int'(bar_time);
            // bars rounded half up, never fewer than one
            run = (2 * int'(ticks) + bar) / (2 * bar);
            if (run == 0)
                run = 1;
            room = CODE_BITS_DEF - int'(held_bits);
            if (run > room)
                run = room;
            repeat (run)
            begin
                code_reg  = {code_reg[CODE_BITS_DEF-2:0], polarity};
                held_bits = held_bits + 4'd1;
                fresh.push_back('{KIND_BIT, polarity, 1'b0, 1'b0});
            end
            polarity = ~polarity;
            if (held_bits >= CODE_BITS_DEF)
            begin
                if (code_reg == user_code[REG_FIRST_CODE])
                    fresh.push_back('{KIND_ACCEPT, 1'b0, 1'b0, 1'b0});
                else if (code_reg == user_code[REG_SECOND_CODE])
                    fresh.push_back('{KIND_ACCEPT, 1'b0, 1'b1, 1'b0});
                else
                    fresh.push_back('{KIND_REJECT, 1'b0, 1'b0, 1'b0});
                clear_card();
            end
        end
        if (fresh.size() > 0)
        begin
            tail = fresh.pop_back();
            tail.last = 1'b1;
            fresh.push_back(tail);
        end
        foreach (fresh[i])
            expected_results.push_back(fresh[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reader_result_t want;
        if (!rst_n)
        begin
            clear_card();
            user_code[REG_FIRST_CODE]  = FIRST_CODE_RST;
            user_code[REG_SECOND_CODE] = SECOND_CODE_RST;
            expected_results.delete();
            mismatches = 0;
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
                user_code[cfg_index] = cfg_data;
            if (in_valid && !in_stall)
                decode_request(action, interval);
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d bit_value %0d user_index %0d last %0d",
                           kind, bit_value, user_index, last);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        mismatches++;
                    end
                    if (bit_value !== want.bit_value)
                    begin
                        $error("bit_value: expected %0d, got %0d", want.bit_value, bit_value);
                        mismatches++;
                    end
                    if (user_index !== want.user_index)
                    begin
                        $error("user_index: expected %0d, got %0d", want.user_index, user_index);
                        mismatches++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        mismatches++;
                    end
                end
            end
            failures    <= mismatches;
            outstanding <= expected_results.size();
        end
    end

endmodule

FILE: bench/bar_width_code_reader_unit_test.sv
// testbench top for the bar width code reader: drives edge and timeout
// requests, user code writes and output stalls, and gives the verdict
// depends on bwcr_pkg, bar_width_code_reader_unit, bar_width_code_reader_checker
module bar_width_code_reader_unit_test;
    import bwcr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic                     cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic                     action;
    logic [TICK_BITS_DEF-1:0] interval;
    logic                     out_valid;
    logic                     out_stall;
    logic [1:0]               kind;
    logic                     bit_value;
    logic                     user_index;
    logic                     last;

    int                       failures;
    int                       outstanding;
    int                       cycles = 0;
    int                       sent = 0;
    logic                     steady = 1'b0;
    logic                     dirty = 1'b0;
    logic [CFG_W-1:0]         code_of_user [2];

    bar_width_code_reader_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .interval   (interval),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .bit_value  (bit_value),
        .user_index (user_index),
        .last       (last)
    );

    bar_width_code_reader_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .interval    (interval),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .bit_value   (bit_value),
        .user_index  (user_index),
        .last        (last),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= !steady && ($urandom_range(0, 99) < 15);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("bar_width_code_reader_unit_test NOT OK");
            $finish;
        end
    end

    task automatic send_request(input logic op, input logic [TICK_BITS_DEF-1:0] ticks);
        if (!steady && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < 40);
        end
        in_valid <= 1'b1;
        action   <= op;
        interval <= ticks;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    // hold off until every expected result is back, then let a pending divide finish
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_user_codes(input logic [CFG_W-1:0] first, input logic [CFG_W-1:0] second);
        cfg_write <= 1'b1;
        cfg_index <= REG_FIRST_CODE;
        cfg_data  <= first;
        @(posedge clk);
        cfg_index <= REG_SECOND_CODE;
        cfg_data  <= second;
        @(posedge clk);
        cfg_write <= 1'b0;
        code_of_user[REG_FIRST_CODE]  = first;
        code_of_user[REG_SECOND_CODE] = second;
    endtask

    // one card: start edge, calibration bars, then runs that spell the code;
    // a cut card stops at a random point with a timeout
    task automatic send_card(input logic [CODE_BITS_DEF-1:0] code, input bit cut_short);
        int runs [$];
        logic [TICK_BITS_DEF-1:0] ticks_list [$];
        int n;
        int bar_hint;
        int bar;
        int total;
        int t;
        int cut_at;
        int stop;
        n = 1;
        for (int i = CODE_BITS_DEF - 2; i >= 0; i--)
        begin
            if (code[i] == code[i+1])
                n++;
            else
            begin
                runs.push_back(n);
                n = 1;
            end
        end
        runs.push_back(n);
        // an overlong final run is clipped by the block
        if ($urandom_range(0, 3) == 0)
        begin
            t = runs[runs.size()-1] + $urandom_range(1, 3);
            runs[runs.size()-1] = (t > CODE_BITS_DEF) ? CODE_BITS_DEF : t;
        end
        case ($urandom_range(0, 7))
            0:       bar_hint = $urandom_range(1, 3);
            1:       bar_hint = $urandom_range(400, 3000);
            default: bar_hint = $urandom_range(4, 400);
        endcase
        ticks_list.push_back(TICK_BITS_DEF'($urandom_range(0, 65535)));
        total = 0;
        repeat (CAL_BARS_DEF)
        begin
            t = bar_hint + $urandom_range(0, bar_hint / 2) - bar_hint / 4;
            total += t;
            ticks_list.push_back(TICK_BITS_DEF'(t));
        end
        bar = total / CAL_BARS_DEF;
        if (bar == 0)
            bar = 1;
        foreach (runs[i])
        begin
            if ($urandom_range(0, 1))
                t = runs[i] * bar + $urandom_range(0, (bar - 1) / 2);
            else
                t = runs[i] * bar - $urandom_range(0, bar / 2);
            ticks_list.push_back(TICK_BITS_DEF'(t));
        end
        cut_at = $urandom_range(1, ticks_list.size() - 1);
        stop = cut_short ? cut_at : ticks_list.size();
        for (int k = 0; k < stop; k++)
            send_request(OP_EDGE, ticks_list[k]);
        if (cut_short)
            send_request(OP_TIMEOUT, TICK_BITS_DEF'($urandom_range(0, 65535)));
    endtask

    function automatic logic [TICK_BITS_DEF-1:0] any_ticks();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return TICK_BITS_DEF'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        int pick;
        int sel;
        logic [CODE_BITS_DEF-1:0] code;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_FIRST_CODE;
        cfg_data  = '0;
        in_valid  = 1'b0;
        action    = OP_EDGE;
        interval  = '0;
        out_stall = 1'b0;
        code_of_user[REG_FIRST_CODE]  = FIRST_CODE_RST;
        code_of_user[REG_SECOND_CODE] = SECOND_CODE_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // timeout while idle gives nothing
        send_request(OP_TIMEOUT, '1);
        // zero calibration clamps the bar time to one; zero interval still
        // yields a bit; a huge interval overflows the code and forces a verdict
        send_request(OP_EDGE, '1);
        repeat (CAL_BARS_DEF) send_request(OP_EDGE, '0);
        send_request(OP_EDGE, '0);
        send_request(OP_EDGE, '1);
        // widest bar time, a short interval, then a timeout with a partial code
        send_request(OP_EDGE, '0);
        repeat (CAL_BARS_DEF) send_request(OP_EDGE, '1);
        send_request(OP_EDGE, 16'd1);
        send_request(OP_TIMEOUT, '0);

        for (int p = 0; p < 4; p++)
        begin
            if (p > 0)
            begin
                settle();
                case (p)
                    1: set_user_codes('1, {1'b1, 13'($urandom)});
                    2:
                    begin
                        // both users match the same card
                        code = {1'b1, 13'($urandom)};
                        set_user_codes(code, code);
                    end
                    default: set_user_codes('0, 14'h2000);
                endcase
            end
            steady = (p == 2);
            while (sent < 20 + (p + 1) * 78)
            begin
                if (p == 1 && sent > 130 && sent < 140)
                    settle();
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    if (dirty)
                        send_request(OP_TIMEOUT, any_ticks());
                    dirty = 1'b0;
                    sel = $urandom_range(0, 9);
                    if (sel < 4)
                        code = code_of_user[REG_FIRST_CODE];
                    else if (sel < 8)
                        code = code_of_user[REG_SECOND_CODE];
                    else
                        code = CODE_BITS_DEF'($urandom);
                    send_card(code, 1'b0);
                end
                else if (pick < 75)
                begin
                    send_card(CODE_BITS_DEF'($urandom), 1'b1);
                    dirty = 1'b0;
                end
                else if (pick < 90)
                begin
                    repeat ($urandom_range(1, 4))
                        send_request($urandom_range(0, 1) ? OP_TIMEOUT : OP_EDGE, any_ticks());
                    dirty = 1'b1;
                end
                else
                begin
                    send_request(OP_TIMEOUT, any_ticks());
                    dirty = 1'b0;
                end
            end
        end
        steady = 1'b0;

        settle();
        if (failures == 0)
            $display("bar_width_code_reader_unit_test OK");
        else
            $display("bar_width_code_reader_unit_test NOT OK");
        $finish;
    end

endmodule
